// File: rtl/bfs_pkg.sv
`timescale 1ns / 1ps
// bfs_pkg: shared types and codes of the route finder.
// Holds the command and result structs, op and status codes, sequencer states.
// No dependencies.
package bfs_pkg;

  localparam int SECTOR_W = 12;

  // Op codes
  localparam logic [2:0] OP_ADD_EDGE    = 3'd0;
  localparam logic [2:0] OP_MARK_AVOID  = 3'd1;
  localparam logic [2:0] OP_SEARCH      = 3'd2;
  localparam logic [2:0] OP_CLR_AVOID   = 3'd3;
  localparam logic [2:0] OP_CLR_ALL     = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SECTOR = 2'd1;
  localparam logic [1:0] ST_NO_PATH   = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  typedef struct packed {
    logic [2:0]          op;
    logic [SECTOR_W-1:0] first_sector;
    logic [SECTOR_W-1:0] second_sector;
  } bfs_cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SECTOR_W-1:0] path_sector;
    logic [5:0]          hop_count;
    logic                last;
  } bfs_rsp_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_E_WR,
    S_A1,
    S_A2,
    S_INIT,
    S_DEQ,
    S_DEQ2,
    S_HEAD,
    S_EDGE,
    S_CHK,
    S_WALK,
    S_WALK2,
    S_OPRE,
    S_OUT
  } bfs_state_t;

endpackage

// File: rtl/bfs_path_buf.sv
`timescale 1ns / 1ps
// bfs_path_buf: small path buffer, one write port, one registered read port.
// Depends on nothing but its parameters.
module bfs_path_buf #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bfs_route_finder_unit.sv
`timescale 1ns / 1ps
// bfs_route_finder_unit: breadth-first shortest-hop route finder.
// Depends on bfs_pkg and bfs_path_buf.
//
// Usage:
//   Command channel: cmd is transferred at a clock edge with start high and busy
//   low. Add edge writes its edge and list head in a write state, mark avoid at
//   the transfer itself. Clear avoids and clear all sweep the sector stores.
//   A search runs the endpoint checks, then a visited-mark sweep over all
//   sectors, then a dequeue and list head read per dequeued sector plus an edge
//   read and check per scanned edge (one sector store port each step), the
//   predecessor walk, then one result per cycle, start sector first.
//   Endpoint errors come in the cycle after the transfer or after the checks.
//   Results: rsp is valid for exactly one cycle with rsp_valid; the receiver
//   cannot stall, so nothing is held back.
//   Config: sector_count written through cfg_valid/cfg_ready/cfg_data, ready
//   always high; write only while idle.
//   Reset: rst clears the edge list heads and avoid marks with a sweep over all
//   sectors, busy stays high meanwhile.
module bfs_route_finder_unit #(
  parameter int MAX_SECTORS = 4096,
  parameter int MAX_EDGES   = 16384,
  parameter int MAX_PATH    = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  bfs_pkg::bfs_cmd_t cmd,
  output logic             rsp_valid,
  output bfs_pkg::bfs_rsp_t rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [11:0]      cfg_data
);
  import bfs_pkg::*;

  localparam int SIW  = $clog2(MAX_SECTORS);
  localparam int EW   = $clog2(MAX_EDGES + 1);
  localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int PW   = $clog2(MAX_PATH + 1);
  localparam int AW   = $clog2(MAX_PATH);
  localparam int BMAX = (MAX_SECTORS - 1 > 4095) ? 4095 : MAX_SECTORS - 1;

  function automatic logic [SIW-1:0] sidx(input logic [SECTOR_W-1:0] s);
    logic [SIW+SECTOR_W-1:0] w;
    w = {{SIW{1'b0}}, s};
    return w[SIW-1:0];
  endfunction

  // state and registers
  bfs_state_t state, state_next;
  logic [11:0]         sector_count;
  logic [EW-1:0]       edges_loaded;
  logic [SIW-1:0]      clr_ptr;
  logic                clr_head, clr_avoid, clr_visit;
  logic [SECTOR_W-1:0] from_s, to_s, a_s, c_s, u_s, v_s, cur;
  logic [EW-1:0]       lnk;
  logic                av1;
  logic [SIW:0]        qh, qt;
  logic [PW-1:0]       n;
  logic [AW-1:0]       ridx;

  // memories
  logic [EW-1:0]          lhead_mem [MAX_SECTORS];
  logic                   avoid_mem [MAX_SECTORS];
  logic                   visit_mem [MAX_SECTORS];
  logic [SECTOR_W-1:0]    pred_mem  [MAX_SECTORS];
  logic [SECTOR_W-1:0]    queue_mem [MAX_SECTORS];
  logic [EW+SECTOR_W-1:0] edge_mem  [MAX_EDGES];

  logic [EW-1:0]          lhead_q;
  logic                   avoid_q, visit_q;
  logic [SECTOR_W-1:0]    pred_q, queue_q, pb_q;
  logic [EW+SECTOR_W-1:0] edge_q;

  logic [SIW-1:0] lhead_ra, avoid_ra;
  logic [EIW-1:0] edge_ra;
  logic [AW-1:0]  pb_ra;
  logic [EW-1:0]  lhm1, lnkm1;
  logic [11:0]    bnd;
  logic           accept, a_ok, c_ok, v_ok, v_new;
  logic [PW+5:0]  hops_w;
  logic           rsp_fire;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);

  // valid sector bound and range checks
  assign bnd  = (sector_count > 12'(BMAX)) ? 12'(BMAX) : sector_count;
  assign a_ok = (cmd.first_sector != '0) && (cmd.first_sector <= bnd);
  assign c_ok = (cmd.second_sector != '0) && (cmd.second_sector <= bnd);
  assign v_ok = (v_s != '0) && (v_s <= bnd);
  assign v_new = v_ok && !avoid_q && !visit_q;

  // read addresses
  assign lhm1     = lhead_q - EW'(1);
  assign lnkm1    = lnk - EW'(1);
  assign lhead_ra = (state == S_DEQ2) ? sidx(queue_q) : sidx(cmd.first_sector);
  always_comb begin
    avoid_ra = sidx(cmd.first_sector);
    if (state == S_A1) avoid_ra = sidx(to_s);
    else if (state == S_EDGE) avoid_ra = sidx(edge_q[SECTOR_W-1:0]);
  end
  assign edge_ra = (state == S_HEAD) ? lhm1[EIW-1:0] : lnkm1[EIW-1:0];
  assign pb_ra   = (state == S_OUT) ? ridx - AW'(1) : ridx;
  assign hops_w  = {6'b0, n - PW'(1)};

  // result strobe: bad endpoints, check outcome, empty frontier, long path, path out
  assign rsp_fire =
      (accept && cmd.op == OP_SEARCH && !(a_ok && c_ok)) ||
      (state == S_A2 && (av1 || avoid_q || from_s == to_s)) ||
      (state == S_DEQ && qh == qt) ||
      (state == S_WALK && cur != from_s && n + PW'(1) == PW'(MAX_PATH)) ||
      (state == S_OUT);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      sector_count <= cfg_data;
    end
  end

  // registered memory reads
  always_ff @(posedge clk) begin
    lhead_q <= lhead_mem[lhead_ra];
    avoid_q <= avoid_mem[avoid_ra];
    visit_q <= visit_mem[sidx(edge_q[SECTOR_W-1:0])];
    pred_q  <= pred_mem[sidx(cur)];
    queue_q <= queue_mem[qh[SIW-1:0]];
    edge_q  <= edge_mem[edge_ra];
  end

  // list head writes
  always_ff @(posedge clk) begin
    if (state == S_CLR && clr_head) begin
      lhead_mem[clr_ptr] <= '0;
    end else if (state == S_E_WR) begin
      lhead_mem[sidx(a_s)] <= edges_loaded + EW'(1);
    end
  end

  // edge store writes
  always_ff @(posedge clk) begin
    if (state == S_E_WR) begin
      edge_mem[edges_loaded[EIW-1:0]] <= {lhead_q, c_s};
    end
  end

  // avoid mark writes
  always_ff @(posedge clk) begin
    if (state == S_CLR && clr_avoid) begin
      avoid_mem[clr_ptr] <= 1'b0;
    end else if (accept && cmd.op == OP_MARK_AVOID && a_ok) begin
      avoid_mem[sidx(cmd.first_sector)] <= 1'b1;
    end
  end

  // visited mark writes
  always_ff @(posedge clk) begin
    if (state == S_CLR && clr_visit) begin
      visit_mem[clr_ptr] <= 1'b0;
    end else if (state == S_INIT) begin
      visit_mem[sidx(from_s)] <= 1'b1;
    end else if (state == S_CHK && v_new) begin
      visit_mem[sidx(v_s)] <= 1'b1;
    end
  end

  // predecessor and frontier queue writes; start sector goes in slot zero
  always_ff @(posedge clk) begin
    if (state == S_CHK && v_new) begin
      pred_mem[sidx(v_s)] <= u_s;
    end
    if (state == S_INIT) begin
      queue_mem['0] <= from_s;
    end else if (state == S_CHK && v_new && qt < (SIW+1)'(MAX_SECTORS)) begin
      queue_mem[qt[SIW-1:0]] <= v_s;
    end
  end

  // path buffer, filled target first during the walk
  bfs_path_buf #(
    .DEPTH(MAX_PATH),
    .AW   (AW),
    .DW   (SECTOR_W)
  ) u_pbuf (
    .clk  (clk),
    .we   (state == S_WALK),
    .waddr(n[AW-1:0]),
    .wdata(cur),
    .raddr(pb_ra),
    .rdata(pb_q)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:   if (clr_ptr == SIW'(MAX_SECTORS - 1)) state_next = clr_visit ? S_INIT : S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (cmd.op) inside
            OP_ADD_EDGE: if (a_ok && c_ok && edges_loaded < EW'(MAX_EDGES)) state_next = S_E_WR;
            OP_SEARCH:   if (a_ok && c_ok) state_next = S_A1;
            OP_CLR_AVOID, OP_CLR_ALL: state_next = S_CLR;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_E_WR:  state_next = S_IDLE;
      S_A1:    state_next = S_A2;
      S_A2:    state_next = (av1 || avoid_q || from_s == to_s) ? S_IDLE : S_CLR;
      S_INIT:  state_next = S_DEQ;
      S_DEQ:   state_next = (qh == qt) ? S_IDLE : S_DEQ2;
      S_DEQ2:  state_next = S_HEAD;
      S_HEAD:  state_next = (lhead_q == '0) ? S_DEQ : S_EDGE;
      S_EDGE:  state_next = S_CHK;
      S_CHK: begin
        if (v_new && v_s == to_s) state_next = S_WALK;
        else if (lnk == '0) state_next = S_DEQ;
        else state_next = S_EDGE;
      end
      S_WALK: begin
        if (cur == from_s) state_next = S_OPRE;
        else if (n + PW'(1) == PW'(MAX_PATH)) state_next = S_IDLE;
        else state_next = S_WALK2;
      end
      S_WALK2: state_next = S_WALK;
      S_OPRE:  state_next = S_OUT;
      S_OUT:   if (ridx == '0) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr      <= '0;
      clr_head     <= 1'b1;
      clr_avoid    <= 1'b1;
      clr_visit    <= 1'b0;
      edges_loaded <= '0;
      qh           <= '0;
      qt           <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      rsp_valid <= rsp_fire;
      unique case (state)
        S_CLR: clr_ptr <= clr_ptr + SIW'(1);
        S_IDLE: begin
          clr_ptr   <= '0;
          clr_visit <= 1'b0;
          if (start) begin
            a_s    <= cmd.first_sector;
            c_s    <= cmd.second_sector;
            from_s <= cmd.first_sector;
            to_s   <= cmd.second_sector;
            case (cmd.op)
              OP_SEARCH: begin
                if (!(a_ok && c_ok)) begin
                  rsp <= '{ST_NO_SECTOR, '0, 6'd0, 1'b1};
                end
              end
              OP_CLR_AVOID: begin
                clr_head  <= 1'b0;
                clr_avoid <= 1'b1;
              end
              OP_CLR_ALL: begin
                clr_head     <= 1'b1;
                clr_avoid    <= 1'b1;
                edges_loaded <= '0;
              end
              default: ;
            endcase
          end
        end
        S_E_WR: edges_loaded <= edges_loaded + EW'(1);
        S_A1: av1 <= avoid_q;
        S_A2: begin
          if (av1 || avoid_q) begin
            rsp <= '{ST_NO_PATH, '0, 6'd0, 1'b1};
          end else if (from_s == to_s) begin
            rsp <= '{ST_OK, from_s, 6'd0, 1'b1};
          end else begin
            clr_head  <= 1'b0;
            clr_avoid <= 1'b0;
            clr_visit <= 1'b1;
          end
        end
        S_INIT: begin
          qh <= '0;
          qt <= (SIW+1)'(1);
        end
        S_DEQ: begin
          if (qh == qt) begin
            rsp <= '{ST_NO_PATH, '0, 6'd0, 1'b1};
          end else begin
            qh <= qh + (SIW+1)'(1);
          end
        end
        S_DEQ2: u_s <= queue_q;
        S_HEAD: ;
        S_EDGE: begin
          v_s <= edge_q[SECTOR_W-1:0];
          lnk <= edge_q[EW+SECTOR_W-1:SECTOR_W];
        end
        S_CHK: begin
          if (v_new && qt < (SIW+1)'(MAX_SECTORS)) qt <= qt + (SIW+1)'(1);
          cur <= to_s;
          n   <= '0;
        end
        S_WALK: begin
          n <= n + PW'(1);
          ridx <= n[AW-1:0];
          if (cur != from_s && n + PW'(1) == PW'(MAX_PATH)) begin
            rsp <= '{ST_TOO_LONG, '0, 6'd0, 1'b1};
          end
        end
        S_WALK2: cur <= pred_q;
        S_OPRE: ;
        S_OUT: begin
          rsp  <= '{ST_OK, pb_q, hops_w[5:0], ridx == '0};
          ridx <= ridx - AW'(1);
        end
        default: ;
      endcase
    end
  end

  // checks
  a_queue_order: assert property (@(posedge clk) disable iff (rst) qh <= qt)
    else $error("frontier head passed tail");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && rsp.status != ST_OK |-> rsp.last)
    else $error("error result without last mark");
  a_search_acts: assert property (@(posedge clk) disable iff (rst)
      accept && cmd.op == OP_SEARCH |=> busy || rsp_valid)
    else $error("search transfer neither started nor answered");
  a_edge_cap: assert property (@(posedge clk) disable iff (rst)
      edges_loaded <= EW'(MAX_EDGES))
    else $error("edge count beyond store size");

endmodule

// File: test/tb_bfs_route_finder_unit.sv
`timescale 1ns / 1ps
// tb_bfs_route_finder_unit: self-checking testbench of the route finder.
// Drives edge loads, avoid marks and searches, predicts every path result
// with its own graph model and compares field by field. Depends on bfs_pkg and bfs_route_finder_unit.
module tb_bfs_route_finder_unit;
  import bfs_pkg::*;

  localparam int NSECT = 4096;
  localparam int NEDGE = 16384;
  localparam int PATH_MAX = 64;
  localparam int DRAIN_CYCLES = 4400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bfs_cmd_t cmd = '0;
  logic rsp_valid;
  bfs_rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [11:0] cfg_data = '0;

  bfs_route_finder_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Stimulus and expectation stores
  bfs_cmd_t pending_cmds[$];
  bfs_rsp_t route_results[$];
  int idle_pct = 0;
  logic xfer_done = 1'b0;
  int mismatches = 0;
  int results_seen = 0;
  int searches_sent = 0;
  int items_sent = 0;

  // Graph model state
  logic [11:0] sector_bound = '0;
  logic [11:0] edge_dst[NEDGE];
  int edge_next[NEDGE];
  int chain_head[NSECT];
  int edge_total = 0;
  bit avoided[NSECT];
  bit seen[NSECT];
  logic [11:0] came_from[NSECT];
  logic [11:0] frontier[NSECT];
  logic [11:0] route[NSECT];

  function automatic bit in_range(logic [11:0] s);
    return s >= 1 && s <= sector_bound;
  endfunction

  function automatic bfs_rsp_t error_rsp(logic [1:0] st, logic [11:0] s);
    bfs_rsp_t r;
    r.status = st;
    r.path_sector = s;
    r.hop_count = '0;
    r.last = 1'b1;
    return r;
  endfunction

  // Breadth-first search; queues the expected path results
  task automatic predict_route(logic [11:0] src, logic [11:0] dst);
    int qh, qt, n, lnk, u, v, k;
    bit found;
    logic [11:0] cur;
    bfs_rsp_t r;
    qh = 0; qt = 0; found = 0;
    if (!in_range(src) || !in_range(dst)) begin
      route_results.push_back(error_rsp(ST_NO_SECTOR, '0));
      return;
    end
    if (avoided[src] || avoided[dst]) begin
      route_results.push_back(error_rsp(ST_NO_PATH, '0));
      return;
    end
    if (src == dst) begin
      route_results.push_back(error_rsp(ST_OK, src));
      return;
    end
    foreach (seen[i]) seen[i] = 0;
    frontier[qt++] = src;
    seen[src] = 1;
    while (qh < qt && !found) begin
      u = frontier[qh++];
      lnk = chain_head[u];
      while (lnk != 0) begin
        v = edge_dst[lnk-1];
        lnk = edge_next[lnk-1];
        if (v < 1 || v > sector_bound || avoided[v] || seen[v]) continue;
        seen[v] = 1;
        came_from[v] = 12'(u);
        if (qt < NSECT) frontier[qt++] = 12'(v);
        if (v == dst) begin
          found = 1;
          break;
        end
      end
    end
    if (!found) begin
      route_results.push_back(error_rsp(ST_NO_PATH, '0));
      return;
    end
    n = 1;
    cur = dst;
    route[0] = dst;
    while (cur != src && n <= NSECT) begin
      cur = came_from[cur];
      route[n] = cur;
      n++;
    end
    if (cur != src) begin
      route_results.push_back(error_rsp(ST_NO_PATH, '0));
    end else if (n > PATH_MAX) begin
      route_results.push_back(error_rsp(ST_TOO_LONG, '0));
    end else begin
      // route[] holds target first; emit start first
      for (k = n - 1; k >= 0; k--) begin
        r.status = ST_OK;
        r.path_sector = route[k];
        r.hop_count = 6'(n - 1);
        r.last = (k == 0);
        route_results.push_back(r);
      end
    end
  endtask

  task automatic apply_cmd(bfs_cmd_t c);
    case (c.op)
      OP_ADD_EDGE: begin
        if (in_range(c.first_sector) && in_range(c.second_sector) &&
            edge_total < NEDGE) begin
          edge_dst[edge_total] = c.second_sector;
          edge_next[edge_total] = chain_head[c.first_sector];
          chain_head[c.first_sector] = edge_total + 1;
          edge_total++;
        end
      end
      OP_MARK_AVOID: if (in_range(c.first_sector)) avoided[c.first_sector] = 1;
      OP_SEARCH: predict_route(c.first_sector, c.second_sector);
      OP_CLR_AVOID: foreach (avoided[i]) avoided[i] = 0;
      OP_CLR_ALL: begin
        foreach (avoided[i]) avoided[i] = 0;
        foreach (chain_head[i]) chain_head[i] = 0;
        edge_total = 0;
      end
      default: ;
    endcase
  endtask

  // Monitor: result check, command and config transfers
  always @(posedge clk) begin
    if (rsp_valid && !rst) begin
      results_seen++;
      if (route_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result status=%0d sector=%0d hops=%0d last=%0d",
                   rsp.status, rsp.path_sector, rsp.hop_count, rsp.last);
      end else begin
        if (rsp !== route_results[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp st=%0d sec=%0d hop=%0d last=%0d",
                     route_results[0].status, route_results[0].path_sector,
                     route_results[0].hop_count, route_results[0].last,
                     " got st=%0d sec=%0d hop=%0d last=%0d",
                     rsp.status, rsp.path_sector, rsp.hop_count, rsp.last);
        end
        void'(route_results.pop_front());
      end
    end
    if (!rst && start && !busy) begin
      apply_cmd(cmd);
      items_sent++;
      if (cmd.op == OP_SEARCH) searches_sent++;
    end
    if (!rst && cfg_valid && cfg_ready) sector_bound = cfg_data;
    xfer_done <= !rst && start && !busy;
  end

  // Driver: holds a command until transferred, idles at random
  always @(negedge clk) begin
    if (!rst && (!start || xfer_done)) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        cmd <= pending_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic send(logic [2:0] op, logic [11:0] a, logic [11:0] b);
    bfs_cmd_t c;
    c.op = op;
    c.first_sector = a;
    c.second_sector = b;
    pending_cmds.push_back(c);
  endtask

  // Wait until all transfers are done and the block has settled
  task automatic drain;
    while (pending_cmds.size() != 0 || start || route_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_bound(logic [11:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random mix of loads, avoid marks, searches, clears and random op codes over sectors near 1..bnd
  task automatic random_mix(int count, int bnd);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        send(OP_ADD_EDGE, 12'($urandom_range(1, bnd + 2)), 12'($urandom_range(1, bnd + 2)));
      else if (r < 50)
        send(OP_MARK_AVOID, 12'($urandom_range(1, bnd + 2)), 12'($urandom));
      else if (r < 82)
        send(OP_SEARCH, 12'($urandom_range(1, bnd + 2)), 12'($urandom_range(1, bnd + 2)));
      else if (r < 88)
        send(OP_CLR_AVOID, 12'($urandom), 12'($urandom));
      else if (r < 90)
        send(OP_CLR_ALL, 12'($urandom), 12'($urandom));
      else
        send(3'($urandom_range(0, 7)), 12'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    foreach (chain_head[i]) chain_head[i] = 0;
    foreach (avoided[i]) avoided[i] = 0;
    foreach (came_from[i]) came_from[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // No sectors exist yet: everything is rejected
    send(OP_SEARCH, 12'd1, 12'd1);
    send(OP_ADD_EDGE, 12'd1, 12'd2);
    send(OP_MARK_AVOID, 12'd1, 12'd0);
    send(3'd5, 12'hFFF, 12'hFFF);
    send(3'd7, 12'd0, 12'd0);
    drain();

    // Widest bound: extremes, avoids, same endpoints, neighbour order
    write_bound(12'd4095);
    send(OP_ADD_EDGE, 12'd4095, 12'd1);
    send(OP_ADD_EDGE, 12'd1, 12'd4095);
    send(OP_SEARCH, 12'd4095, 12'd1);
    send(OP_SEARCH, 12'd1, 12'd4095);
    send(OP_SEARCH, 12'd0, 12'd5);
    send(OP_SEARCH, 12'd5, 12'd0);
    send(OP_SEARCH, 12'd5, 12'd5);
    send(OP_MARK_AVOID, 12'd4095, 12'd0);
    send(OP_SEARCH, 12'd1, 12'd4095);
    send(OP_CLR_AVOID, 12'd0, 12'd0);
    send(OP_ADD_EDGE, 12'd1, 12'd2);
    send(OP_ADD_EDGE, 12'd1, 12'd3);
    send(OP_ADD_EDGE, 12'd2, 12'd4);
    send(OP_ADD_EDGE, 12'd3, 12'd4);
    send(OP_SEARCH, 12'd1, 12'd4);
    send(OP_MARK_AVOID, 12'd3, 12'd0);
    send(OP_SEARCH, 12'd1, 12'd4);
    send(OP_CLR_ALL, 12'd0, 12'd0);
    send(OP_SEARCH, 12'd1, 12'd4);
    send(3'd6, 12'hAAA, 12'h555);
    drain();

    // Random phases, different bounds and idle patterns
    write_bound(12'd12);
    idle_pct = 0;
    random_mix(10, 12);
    drain();
    // Lowered bound hides stored edges
    write_bound(12'd6);
    idle_pct = 77;
    random_mix(10, 6);
    drain();
    write_bound(12'd30);
    idle_pct = 6;
    random_mix(10, 30);
    drain();

    // Long chain: paths of 64 sectors pass, longer ones are rejected
    write_bound(12'd100);
    idle_pct = 0;
    send(OP_CLR_ALL, 12'd0, 12'd0);
    for (int s = 1; s < 67; s++) send(OP_ADD_EDGE, 12'(s), 12'(s + 1));
    send(OP_SEARCH, 12'd1, 12'd64);
    send(OP_SEARCH, 12'd1, 12'd65);
    send(OP_SEARCH, 12'd1, 12'd67);
    send(OP_SEARCH, 12'd3, 12'd40);
    drain();

    $display("Covered %0d transfers, %0d searches, %0d results checked.",
             items_sent, searches_sent, results_seen);
    $display("Bounds 0, 6, 12, 30, 100 and 4095 with avoids, clears and long paths.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bfs_pkg.sv
rtl/bfs_path_buf.sv
rtl/bfs_route_finder_unit.sv
test/tb_bfs_route_finder_unit.sv
